/* design/gtn_pkg.sv */
// Shared types, codes and defaults for the grid two-nearest node store.
package gtn_pkg;

  // Default sizes of the store
  localparam int DEF_MAX_NODES      = 1024;
  localparam int DEF_SLOTS_PER_CELL = 10;
  localparam int DEF_CELLS_X        = 16;
  localparam int DEF_CELLS_Y        = 16;
  localparam int DEF_CELLS_Z        = 16;

  // Fixed field widths of the request and result
  localparam int MODE_W  = 2;
  localparam int POS_W   = 16;
  localparam int ID_W    = 10;
  localparam int LABEL_W = 2;
  localparam int DIST_W  = 36;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;
  localparam int INV_W   = 16;
  localparam int INV_RESET = 256;
  localparam int NUM_LABELS = 4;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_MOVE   = 2'd1,
    MODE_DELETE = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X = 3'd0,
    CFG_ORIGIN_Y = 3'd1,
    CFG_ORIGIN_Z = 3'd2,
    CFG_INV_CELL = 3'd3,
    CFG_VIG_L0   = 3'd4,
    CFG_VIG_L1   = 3'd5,
    CFG_VIG_L2   = 3'd6,
    CFG_VIG_L3   = 3'd7
  } cfg_reg_t;

  // Controller states; each also names the datapath action of that cycle
  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CALC,
    ST_INDEX,
    ST_DISPATCH,
    ST_ADD_CHK,
    ST_ADD_SCAN,
    ST_ADD_TEST,
    ST_ADD_WRITE,
    ST_MOV_CHK,
    ST_MOV_ROW,
    ST_MOV_INS,
    ST_DEL_CHK,
    ST_REM,
    ST_Q_CELL,
    ST_Q_ROW,
    ST_Q_NODE,
    ST_Q_SQR,
    ST_Q_CMP,
    ST_DONE
  } step_t;

  typedef struct packed {
    step_t step;
    logic  accept;
  } gtn_cmd_t;

  typedef struct packed {
    logic  clear_done;
    mode_t mode;
    logic  add_ok;
    logic  tgt_ok;
    logic  del_live_ok;
    logic  win_empty;
    logic  in_range;
    logic  row_full;
    logic  row_zero;
    logic  vbit;
    logic  same_cell;
    logic  free_found;
    logic  scan_last;
    logic  slot_last;
    logic  cell_last;
    logic  out_free;
  } gtn_stat_t;

endpackage

/* design/gtn_ctrl.sv */
// Controller state machine sequencing each request through the datapath.
module gtn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gtn_pkg::gtn_stat_t stat,
  output gtn_pkg::gtn_cmd_t  cmd
);
  import gtn_pkg::*;

  step_t state_r, state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Pick the next state and drive the commands
  always_comb begin
    state_nxt  = state_r;
    in_stall   = (state_r != ST_IDLE);
    cmd.step   = state_r;
    cmd.accept = (state_r == ST_IDLE) && in_valid;
    case (state_r)
      ST_CLEAR:    if (stat.clear_done) state_nxt = ST_IDLE;
      ST_IDLE:     if (in_valid) state_nxt = ST_CALC;
      ST_CALC:     state_nxt = ST_INDEX;
      ST_INDEX:    state_nxt = ST_DISPATCH;
      ST_DISPATCH: begin
        case (stat.mode)
          MODE_ADD:    state_nxt = stat.add_ok ? ST_ADD_CHK : ST_DONE;
          MODE_MOVE:   state_nxt = stat.tgt_ok ? ST_MOV_CHK : ST_DONE;
          MODE_DELETE: state_nxt = (stat.tgt_ok && stat.del_live_ok) ? ST_DEL_CHK : ST_DONE;
          MODE_QUERY:  state_nxt = stat.win_empty ? ST_DONE : ST_Q_CELL;
          default:     state_nxt = ST_DONE;
        endcase
      end
      ST_ADD_CHK:   state_nxt = stat.row_full ? ST_DONE : ST_ADD_SCAN;
      ST_ADD_SCAN:  state_nxt = ST_ADD_TEST;
      ST_ADD_TEST: begin
        if (stat.free_found) state_nxt = ST_ADD_WRITE;
        else if (stat.scan_last) state_nxt = ST_DONE;
        else state_nxt = ST_ADD_SCAN;
      end
      ST_ADD_WRITE: state_nxt = ST_DONE;
      ST_MOV_CHK: begin
        if (!(stat.vbit && stat.in_range) || stat.same_cell) state_nxt = ST_DONE;
        else state_nxt = ST_MOV_ROW;
      end
      ST_MOV_ROW:   state_nxt = ST_MOV_INS;
      ST_MOV_INS:   state_nxt = stat.row_full ? ST_DONE : ST_REM;
      ST_DEL_CHK:   state_nxt = stat.vbit ? ST_REM : ST_DONE;
      ST_REM:       state_nxt = ST_DONE;
      ST_Q_CELL:    state_nxt = ST_Q_ROW;
      ST_Q_ROW: begin
        if (!stat.row_zero) state_nxt = ST_Q_NODE;
        else state_nxt = stat.cell_last ? ST_DONE : ST_Q_CELL;
      end
      ST_Q_NODE:    state_nxt = ST_Q_SQR;
      ST_Q_SQR:     state_nxt = ST_Q_CMP;
      ST_Q_CMP: begin
        if (!stat.slot_last) state_nxt = ST_Q_NODE;
        else state_nxt = stat.cell_last ? ST_DONE : ST_Q_CELL;
      end
      ST_DONE:      if (stat.out_free) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* design/gtn_dp.sv */
// Datapath: configuration, node and cell memories, cell index and nearest-two search.
module gtn_dp #(
  parameter int MAX_NODES      = gtn_pkg::DEF_MAX_NODES,
  parameter int SLOTS_PER_CELL = gtn_pkg::DEF_SLOTS_PER_CELL,
  parameter int CELLS_X        = gtn_pkg::DEF_CELLS_X,
  parameter int CELLS_Y        = gtn_pkg::DEF_CELLS_Y,
  parameter int CELLS_Z        = gtn_pkg::DEF_CELLS_Z
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  gtn_pkg::gtn_cmd_t                     cmd,
  output gtn_pkg::gtn_stat_t                    stat,
  input  logic                                  cfg_wr_en,
  input  logic [gtn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gtn_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
  input  logic [gtn_pkg::MODE_W-1:0]            in_mode,
  input  logic signed [gtn_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [gtn_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [gtn_pkg::POS_W-1:0]      in_pos_z,
  input  logic [gtn_pkg::ID_W-1:0]              in_target_id,
  input  logic [gtn_pkg::LABEL_W-1:0]           in_new_label,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_status,
  output logic [gtn_pkg::ID_W-1:0]              out_added_id,
  output logic                                  out_first_found,
  output logic [gtn_pkg::ID_W-1:0]              out_first_id,
  output logic [gtn_pkg::DIST_W-1:0]            out_first_dist2,
  output logic                                  out_second_found,
  output logic [gtn_pkg::ID_W-1:0]              out_second_id,
  output logic [gtn_pkg::DIST_W-1:0]            out_second_dist2,
  output logic                                  out_in_vigilance
);
  import gtn_pkg::*;

  localparam int NCELL  = CELLS_X * CELLS_Y * CELLS_Z;
  localparam int IDW    = $clog2(MAX_NODES);
  localparam int LVW    = $clog2(MAX_NODES + 1);
  localparam int CNW    = $clog2(SLOTS_PER_CELL + 1);
  localparam int SLW    = (SLOTS_PER_CELL > 1) ? $clog2(SLOTS_PER_CELL) : 1;
  localparam int CIW    = (NCELL > 1) ? $clog2(NCELL) : 1;
  localparam int XW     = (CELLS_X > 1) ? $clog2(CELLS_X) : 1;
  localparam int YW     = (CELLS_Y > 1) ? $clog2(CELLS_Y) : 1;
  localparam int ZW     = (CELLS_Z > 1) ? $clog2(CELLS_Z) : 1;
  localparam int VW     = (MAX_NODES < 32) ? (1 << $clog2(MAX_NODES)) : 32;
  localparam int VBW    = $clog2(VW);
  localparam int VWORDS = (MAX_NODES + VW - 1) / VW;
  localparam int VAW    = (VWORDS > 1) ? $clog2(VWORDS) : 1;
  localparam int CLR_N  = (NCELL > VWORDS) ? NCELL : VWORDS;
  localparam int CLW    = $clog2(CLR_N + 1);
  localparam int RW     = CNW + SLOTS_PER_CELL * IDW;
  localparam int LOCW   = CIW + SLW;
  localparam int PW     = 3 * POS_W;
  localparam int SQW    = 2 * (POS_W + 1);
  localparam int CW     = 18;
  localparam int LIM [3] = '{CELLS_X, CELLS_Y, CELLS_Z};

  // Row helpers: count in the low bits, then one id per slot
  function automatic logic [CNW-1:0] row_cnt(input logic [RW-1:0] row);
    return row[CNW-1:0];
  endfunction

  function automatic logic [IDW-1:0] row_id(input logic [RW-1:0] row,
                                            input logic [SLW-1:0] s);
    return row[CNW + IDW * s +: IDW];
  endfunction

  function automatic logic [RW-1:0] row_put(input logic [RW-1:0] row,
                                            input logic [SLW-1:0] s,
                                            input logic [IDW-1:0] id,
                                            input logic [CNW-1:0] cnt);
    logic [RW-1:0] r;
    r = row;
    r[CNW + IDW * s +: IDW] = id;
    r[CNW-1:0] = cnt;
    return r;
  endfunction

  // Configuration
  logic signed [POS_W-1:0]  org_r [3];
  logic [INV_W-1:0]         inv_r;
  logic [DIST_W-1:0]        vig_r [NUM_LABELS];

  // Request
  mode_t                    mode_r;
  logic signed [POS_W-1:0]  px_r [3];
  logic [ID_W-1:0]          tgt_r;
  logic [LABEL_W-1:0]       lab_in_r;

  // Cell index
  logic signed [33:0]       prod_r [3];
  logic                     dneg_r [3];
  logic [CIW-1:0]           newcell_r;
  logic                     inr_r, empty_r;
  logic [XW-1:0]            lox_r, hix_r, qx_r;
  logic [YW-1:0]            loy_r, hiy_r, qy_r;
  logic [ZW-1:0]            loz_r, hiz_r, qz_r;

  // Bookkeeping
  logic [LVW-1:0]           live_r;
  logic [CLW-1:0]           clr_r;
  logic [VAW-1:0]           w_r;
  logic [VW-1:0]            vword_r;
  logic [VBW-1:0]           fbit_r;
  logic [IDW-1:0]           nid_r;
  logic [RW-1:0]            row_r;
  logic [CIW-1:0]           tcell_r;
  logic [SLW-1:0]           tslot_r;
  logic [SLW-1:0]           qslot_r;
  logic [IDW-1:0]           qid_r;
  logic [LABEL_W-1:0]       qlab_r;
  logic [SQW-1:0]           sq_r [3];

  // Result being built and the output register
  logic                     res_status_r, res_f1_r, res_f2_r, res_vig_r;
  logic [ID_W-1:0]          res_added_r, res_id1_r, res_id2_r;
  logic [DIST_W-1:0]        res_d1_r, res_d2_r;
  logic                     out_valid_r;

  // Memories
  logic [RW-1:0]            cell_mem [NCELL];
  logic [RW-1:0]            cell_rd_r;
  logic [VW-1:0]            vld_mem [VWORDS];
  logic [VW-1:0]            vld_rd_r;
  logic [PW-1:0]            pos_mem [MAX_NODES];
  logic [PW-1:0]            pos_rd_r;
  logic [LABEL_W-1:0]       lab_mem [MAX_NODES];
  logic [LABEL_W-1:0]       lab_rd_r;
  logic [LOCW-1:0]          loc_mem [MAX_NODES];
  logic [LOCW-1:0]          loc_rd_r;

  logic                     cwe, vwe, pwe, lwe, owe;
  logic [CIW-1:0]           cra, cwa;
  logic [RW-1:0]            cwd;
  logic [VAW-1:0]           vra, vwa;
  logic [VW-1:0]            vwd;
  logic [IDW-1:0]           nra, pwa, owa;
  logic [PW-1:0]            pwd;
  logic [LOCW-1:0]          owd;

  // Combinational helpers
  logic signed [POS_W:0]    d_w [3];
  logic signed [33:0]       prod_w [3];
  logic [33:0]              mag_w [3];
  logic signed [CW-1:0]     coord_w [3];
  logic signed [CW-1:0]     lo_w [3];
  logic signed [CW-1:0]     hi_w [3];
  logic                     inr_w, empty_w;
  logic [CIW-1:0]           newcell_w, qcell_w;
  logic [IDW-1:0]           tid;
  logic [VAW-1:0]           tword;
  logic [VBW-1:0]           tbit;
  logic [CIW-1:0]           ld_cell;
  logic [SLW-1:0]           ld_slot;
  logic [CNW-1:0]           rd_cnt;
  logic [VW-1:0]            vmask_w;
  logic                     found_w;
  logic [VBW-1:0]           fbit_w;
  logic [IDW:0]             idx_w;
  logic [CNW-1:0]           rem_last;
  logic                     rem_ok;
  logic [IDW-1:0]           mover_w;
  logic signed [POS_W:0]    dq_w [3];
  logic [DIST_W-1:0]        dist_w;
  logic                     cell_last_w, slot_last_w, out_free_w;

  assign tid     = IDW'(tgt_r);
  assign tword   = VAW'(tid >> VBW);
  assign tbit    = tid[VBW-1:0];
  assign ld_cell = loc_rd_r[LOCW-1:SLW];
  assign ld_slot = loc_rd_r[SLW-1:0];
  assign rd_cnt  = row_cnt(cell_rd_r);

  // Per-axis offset, product, truncated coordinate and window
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      d_w[a]     = (POS_W+1)'(px_r[a]) - (POS_W+1)'(org_r[a]);
      prod_w[a]  = 34'(d_w[a]) * $signed({18'd0, inv_r});
      mag_w[a]   = prod_r[a][33] ? 34'(-prod_r[a]) : 34'(prod_r[a]);
      coord_w[a] = prod_r[a][33] ? -$signed({2'd0, mag_w[a][33:18]})
                                 : $signed({2'd0, mag_w[a][33:18]});
      lo_w[a]    = (coord_w[a] < 18'sd1) ? 18'sd0 : coord_w[a] - 18'sd1;
      hi_w[a]    = (coord_w[a] + 18'sd1 > CW'(LIM[a] - 1)) ? CW'(LIM[a] - 1)
                                                          : coord_w[a] + 18'sd1;
    end
    inr_w = 1'b1;
    empty_w = 1'b0;
    for (int a = 0; a < 3; a++) begin
      if (dneg_r[a] || coord_w[a] >= CW'(LIM[a])) inr_w = 1'b0;
      if (lo_w[a] > hi_w[a]) empty_w = 1'b1;
    end
    newcell_w = CIW'(coord_w[0][XW-1:0])
              + CIW'(CIW'(coord_w[1][YW-1:0]) * CIW'(CELLS_X))
              + CIW'(CIW'(coord_w[2][ZW-1:0]) * CIW'(CELLS_X * CELLS_Y));
    qcell_w   = CIW'(qx_r)
              + CIW'(CIW'(qy_r) * CIW'(CELLS_X))
              + CIW'(CIW'(qz_r) * CIW'(CELLS_X * CELLS_Y));
  end

  // Find the lowest free id in the fetched valid word
  always_comb begin
    found_w = 1'b0;
    fbit_w  = '0;
    for (int b = 0; b < VW; b++) begin
      idx_w = ((IDW+1)'(w_r) << VBW) | (IDW+1)'(b);
      vmask_w[b] = vld_rd_r[b] || (idx_w >= (IDW+1)'(MAX_NODES));
    end
    for (int b = VW - 1; b >= 0; b--) begin
      if (!vmask_w[b]) begin
        found_w = 1'b1;
        fbit_w  = VBW'(b);
      end
    end
  end

  // Removal from the old cell: last entry fills the emptied slot
  assign rem_last = rd_cnt - CNW'(1);
  assign rem_ok   = (rd_cnt != '0) && (CNW'(tslot_r) < CNW'(SLOTS_PER_CELL));
  assign mover_w  = row_id(cell_rd_r, SLW'(rem_last));

  // Query distance
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dq_w[a] = (POS_W+1)'(px_r[a]) - (POS_W+1)'($signed(pos_rd_r[a*POS_W +: POS_W]));
    end
    dist_w = DIST_W'(sq_r[0]) + DIST_W'(sq_r[1]) + DIST_W'(sq_r[2]);
  end

  assign cell_last_w = (qx_r == hix_r) && (qy_r == hiy_r) && (qz_r == hiz_r);
  assign slot_last_w = (CNW'(qslot_r) + CNW'(1)) == row_cnt(row_r);
  assign out_free_w  = !out_valid_r || !out_stall;

  // Status to the controller
  always_comb begin
    stat.clear_done  = (clr_r == CLW'(CLR_N - 1));
    stat.mode        = mode_r;
    stat.add_ok      = (live_r < LVW'(MAX_NODES)) && inr_r;
    stat.tgt_ok      = (17'(tgt_r) < 17'(MAX_NODES));
    stat.del_live_ok = (live_r > LVW'(2));
    stat.win_empty   = empty_r;
    stat.in_range    = inr_r;
    stat.row_full    = (rd_cnt >= CNW'(SLOTS_PER_CELL));
    stat.row_zero    = (rd_cnt == '0);
    stat.vbit        = vld_rd_r[tbit];
    stat.same_cell   = (ld_cell == newcell_r);
    stat.free_found  = found_w;
    stat.scan_last   = (w_r == VAW'(VWORDS - 1));
    stat.slot_last   = slot_last_w;
    stat.cell_last   = cell_last_w;
    stat.out_free    = out_free_w;
  end

  // Memory addresses and writes for each step
  always_comb begin
    cra = newcell_r;
    cwe = 1'b0;
    cwa = newcell_r;
    cwd = cell_rd_r;
    vra = tword;
    vwe = 1'b0;
    vwa = tword;
    vwd = vld_rd_r;
    nra = tid;
    pwe = 1'b0;
    pwa = tid;
    pwd = {px_r[2], px_r[1], px_r[0]};
    lwe = 1'b0;
    owe = 1'b0;
    owa = tid;
    owd = {newcell_r, SLW'(rd_cnt)};
    case (cmd.step)
      ST_CLEAR: begin
        cwe = (clr_r < CLW'(NCELL));
        cwa = CIW'(clr_r);
        cwd = '0;
        vwe = (clr_r < CLW'(VWORDS));
        vwa = VAW'(clr_r);
        vwd = '0;
      end
      ST_ADD_SCAN, ST_ADD_TEST: vra = w_r;
      ST_ADD_WRITE: begin
        vra = w_r;
        vwe = 1'b1;
        vwa = w_r;
        vwd = vword_r | (VW'(1) << fbit_r);
        pwe = 1'b1;
        pwa = nid_r;
        lwe = 1'b1;
        owe = 1'b1;
        owa = nid_r;
        owd = {newcell_r, SLW'(row_cnt(row_r))};
        cwe = 1'b1;
        cwd = row_put(row_r, SLW'(row_cnt(row_r)), nid_r, row_cnt(row_r) + CNW'(1));
      end
      ST_MOV_CHK: begin
        pwe = stat.vbit && inr_r && stat.same_cell;
      end
      ST_MOV_INS: begin
        cra = tcell_r;
        if (!stat.row_full) begin
          cwe = 1'b1;
          cwd = row_put(cell_rd_r, SLW'(rd_cnt), tid, rd_cnt + CNW'(1));
          pwe = 1'b1;
          owe = 1'b1;
        end
      end
      ST_DEL_CHK: begin
        cra = ld_cell;
        vwe = stat.vbit;
        vwd = vld_rd_r & ~(VW'(1) << tbit);
      end
      ST_REM: begin
        cra = tcell_r;
        cwa = tcell_r;
        cwe = rem_ok;
        if (CNW'(tslot_r) != rem_last) begin
          cwd = row_put(cell_rd_r, tslot_r, mover_w, rem_last);
          owe = rem_ok;
          owa = mover_w;
          owd = {tcell_r, tslot_r};
        end else begin
          cwd = {cell_rd_r[RW-1:CNW], rem_last};
        end
      end
      ST_Q_CELL, ST_Q_ROW: cra = qcell_w;
      ST_Q_NODE: nra = row_id(row_r, qslot_r);
      default: ;
    endcase
  end

  // Memory arrays with registered reads
  always_ff @(posedge clk) begin
    if (cwe) cell_mem[cwa] <= cwd;
    cell_rd_r <= cell_mem[cra];
    if (vwe) vld_mem[vwa] <= vwd;
    vld_rd_r <= vld_mem[vra];
    if (pwe) pos_mem[pwa] <= pwd;
    pos_rd_r <= pos_mem[nra];
    if (lwe) lab_mem[pwa] <= lab_in_r;
    lab_rd_r <= lab_mem[nra];
    if (owe) loc_mem[owa] <= owd;
    loc_rd_r <= loc_mem[nra];
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) org_r[a] <= '0;
      inv_r <= INV_W'(INV_RESET);
      for (int l = 0; l < NUM_LABELS; l++) vig_r[l] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_ORIGIN_X: org_r[0] <= cfg_wr_data[POS_W-1:0];
        CFG_ORIGIN_Y: org_r[1] <= cfg_wr_data[POS_W-1:0];
        CFG_ORIGIN_Z: org_r[2] <= cfg_wr_data[POS_W-1:0];
        CFG_INV_CELL: inv_r    <= cfg_wr_data[INV_W-1:0];
        CFG_VIG_L0:   vig_r[0] <= cfg_wr_data;
        CFG_VIG_L1:   vig_r[1] <= cfg_wr_data;
        CFG_VIG_L2:   vig_r[2] <= cfg_wr_data;
        CFG_VIG_L3:   vig_r[3] <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // Control counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.step == ST_CLEAR && !stat.clear_done) clr_r <= clr_r + CLW'(1);
      if (cmd.step == ST_ADD_WRITE) live_r <= live_r + LVW'(1);
      if (cmd.step == ST_DEL_CHK && stat.vbit) live_r <= live_r - LVW'(1);
      if (cmd.step == ST_DONE && out_free_w) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  // Payload and working registers
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= mode_t'(in_mode);
      px_r[0]  <= in_pos_x;
      px_r[1]  <= in_pos_y;
      px_r[2]  <= in_pos_z;
      tgt_r    <= in_target_id;
      lab_in_r <= in_new_label;
      res_status_r <= 1'b1;
      res_added_r  <= '0;
      res_f1_r  <= 1'b0;
      res_id1_r <= '0;
      res_d1_r  <= '0;
      res_f2_r  <= 1'b0;
      res_id2_r <= '0;
      res_d2_r  <= '0;
      res_vig_r <= 1'b0;
    end
    case (cmd.step)
      ST_CALC: begin
        for (int a = 0; a < 3; a++) begin
          prod_r[a] <= prod_w[a];
          dneg_r[a] <= d_w[a][POS_W];
        end
      end
      ST_INDEX: begin
        inr_r     <= inr_w;
        empty_r   <= empty_w;
        newcell_r <= newcell_w;
        lox_r <= XW'(lo_w[0]);
        hix_r <= XW'(hi_w[0]);
        loy_r <= YW'(lo_w[1]);
        hiy_r <= YW'(hi_w[1]);
        loz_r <= ZW'(lo_w[2]);
        hiz_r <= ZW'(hi_w[2]);
      end
      ST_DISPATCH: begin
        w_r  <= '0;
        qx_r <= lox_r;
        qy_r <= loy_r;
        qz_r <= loz_r;
        if (mode_r == MODE_QUERY) res_status_r <= 1'b0;
      end
      ST_ADD_CHK: row_r <= cell_rd_r;
      ST_ADD_TEST: begin
        vword_r <= vld_rd_r;
        fbit_r  <= fbit_w;
        nid_r   <= IDW'(((IDW+1)'(w_r) << VBW) | (IDW+1)'(fbit_w));
        if (!found_w) w_r <= w_r + VAW'(1);
      end
      ST_ADD_WRITE: begin
        res_status_r <= 1'b0;
        res_added_r  <= ID_W'(nid_r);
      end
      ST_MOV_CHK: begin
        tcell_r <= ld_cell;
        tslot_r <= ld_slot;
        if (stat.vbit && inr_r && stat.same_cell) res_status_r <= 1'b0;
      end
      ST_MOV_INS: if (!stat.row_full) res_status_r <= 1'b0;
      ST_DEL_CHK: begin
        tcell_r <= ld_cell;
        tslot_r <= ld_slot;
        if (stat.vbit) res_status_r <= 1'b0;
      end
      ST_Q_ROW: begin
        row_r   <= cell_rd_r;
        qslot_r <= '0;
      end
      ST_Q_NODE: qid_r <= row_id(row_r, qslot_r);
      ST_Q_SQR: begin
        qlab_r <= lab_rd_r;
        for (int a = 0; a < 3; a++) sq_r[a] <= SQW'(dq_w[a] * dq_w[a]);
      end
      ST_Q_CMP: begin
        // Keep the nearest two; earlier candidates win ties
        if (!res_f2_r || dist_w < res_d2_r) begin
          if (!res_f1_r || dist_w < res_d1_r) begin
            res_f2_r  <= res_f1_r;
            res_id2_r <= res_id1_r;
            res_d2_r  <= res_d1_r;
            res_f1_r  <= 1'b1;
            res_id1_r <= ID_W'(qid_r);
            res_d1_r  <= dist_w;
          end else begin
            res_f2_r  <= 1'b1;
            res_id2_r <= ID_W'(qid_r);
            res_d2_r  <= dist_w;
          end
        end
        if (dist_w < vig_r[qlab_r]) res_vig_r <= 1'b1;
        qslot_r <= qslot_r + SLW'(1);
      end
      default: ;
    endcase
    // Advance through the window: z innermost, then y, then x
    if ((cmd.step == ST_Q_ROW && stat.row_zero) ||
        (cmd.step == ST_Q_CMP && slot_last_w)) begin
      if (qz_r != hiz_r) begin
        qz_r <= qz_r + ZW'(1);
      end else begin
        qz_r <= loz_r;
        if (qy_r != hiy_r) begin
          qy_r <= qy_r + YW'(1);
        end else begin
          qy_r <= loy_r;
          qx_r <= qx_r + XW'(1);
        end
      end
    end
    // Load the output register
    if (cmd.step == ST_DONE && out_free_w) begin
      out_status       <= res_status_r;
      out_added_id     <= res_added_r;
      out_first_found  <= res_f1_r;
      out_first_id     <= res_id1_r;
      out_first_dist2  <= res_d1_r;
      out_second_found <= res_f2_r;
      out_second_id    <= res_id2_r;
      out_second_dist2 <= res_d2_r;
      out_in_vigilance <= res_vig_r;
    end
  end

  assign out_valid = out_valid_r;

  // Live count changes only on a committed add or delete
  a_live_change: assert property (@(posedge clk) disable iff (!rst_n)
    (live_r != $past(live_r)) |->
      ($past(cmd.step) == ST_ADD_WRITE || $past(cmd.step) == ST_DEL_CHK))
    else $error("live count changed outside add or delete");

  // Live count never exceeds the node capacity
  a_live_max: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LVW'(MAX_NODES))
    else $error("live count above capacity");

  // A result appears only after the done step
  a_out_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(cmd.step) == ST_DONE))
    else $error("result raised outside done step");

  // An add only writes into a cell that has room
  a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step == ST_ADD_WRITE) |-> (row_cnt(row_r) < CNW'(SLOTS_PER_CELL)))
    else $error("add into a full cell");

endmodule

/* design/grid_two_nearest_node_store.sv */
// Grid node store: keeps 3D nodes in a uniform grid of cells, each cell listing up to
// SLOTS_PER_CELL node ids, and serves add, move, delete and nearest-two query requests one
// at a time. After reset the block zeroes the cell counts and node valid words before it
// takes its first request; configuration writes are taken throughout. A request passes
// offset, index and dispatch steps, then: an add checks the cell and scans the 32-id valid
// words for the lowest free id; a move checks the node and, for another cell, fills that
// cell and removes the node from its old one; a delete checks and removes; a query reads
// each cell in the 3x3x3 window and, per node found there, fetches its position from the
// node memory, squares and compares. A done step hands the result to the output register,
// which holds it while the next request is taken.
module grid_two_nearest_node_store #(
  parameter int MAX_NODES      = gtn_pkg::DEF_MAX_NODES,
  parameter int SLOTS_PER_CELL = gtn_pkg::DEF_SLOTS_PER_CELL,
  parameter int CELLS_X        = gtn_pkg::DEF_CELLS_X,
  parameter int CELLS_Y        = gtn_pkg::DEF_CELLS_Y,
  parameter int CELLS_Z        = gtn_pkg::DEF_CELLS_Z
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_wr_en,
  input  logic [gtn_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [gtn_pkg::CFG_DATA_W-1:0]        cfg_wr_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [gtn_pkg::MODE_W-1:0]            in_mode,
  input  logic signed [gtn_pkg::POS_W-1:0]      in_pos_x,
  input  logic signed [gtn_pkg::POS_W-1:0]      in_pos_y,
  input  logic signed [gtn_pkg::POS_W-1:0]      in_pos_z,
  input  logic [gtn_pkg::ID_W-1:0]              in_target_id,
  input  logic [gtn_pkg::LABEL_W-1:0]           in_new_label,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic                                  out_status,
  output logic [gtn_pkg::ID_W-1:0]              out_added_id,
  output logic                                  out_first_found,
  output logic [gtn_pkg::ID_W-1:0]              out_first_id,
  output logic [gtn_pkg::DIST_W-1:0]            out_first_dist2,
  output logic                                  out_second_found,
  output logic [gtn_pkg::ID_W-1:0]              out_second_id,
  output logic [gtn_pkg::DIST_W-1:0]            out_second_dist2,
  output logic                                  out_in_vigilance
);
  import gtn_pkg::*;

  gtn_cmd_t  cmd;
  gtn_stat_t stat;

  // Sequence each request
  gtn_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Store, index and search
  gtn_dp #(
    .MAX_NODES      (MAX_NODES),
    .SLOTS_PER_CELL (SLOTS_PER_CELL),
    .CELLS_X        (CELLS_X),
    .CELLS_Y        (CELLS_Y),
    .CELLS_Z        (CELLS_Z)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wr_data      (cfg_wr_data),
    .in_mode          (in_mode),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_pos_z         (in_pos_z),
    .in_target_id     (in_target_id),
    .in_new_label     (in_new_label),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_added_id     (out_added_id),
    .out_first_found  (out_first_found),
    .out_first_id     (out_first_id),
    .out_first_dist2  (out_first_dist2),
    .out_second_found (out_second_found),
    .out_second_id    (out_second_id),
    .out_second_dist2 (out_second_dist2),
    .out_in_vigilance (out_in_vigilance)
  );

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the grid two-nearest node store: adds, moves, deletes, queries.
module tb_top;
  import gtn_pkg::*;

  localparam int NODES      = DEF_MAX_NODES;
  localparam int SLOTS      = DEF_SLOTS_PER_CELL;
  localparam int GRID       = DEF_CELLS_X;
  localparam int NCELLS     = DEF_CELLS_X * DEF_CELLS_Y * DEF_CELLS_Z;
  localparam int STUCK_LIMIT = 20000;
  localparam longint unsigned VIG_MAX = 64'hF_FFFF_FFFF;

  typedef struct {
    bit        status;
    bit [9:0]  added_id;
    bit        f1;
    bit [9:0]  id1;
    bit [35:0] d1;
    bit        f2;
    bit [9:0]  id2;
    bit [35:0] d2;
    bit        vig;
  } answer_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;
  logic in_valid, in_stall;
  logic [MODE_W-1:0] in_mode;
  logic signed [POS_W-1:0] in_pos_x, in_pos_y, in_pos_z;
  logic [ID_W-1:0] in_target_id;
  logic [LABEL_W-1:0] in_new_label;
  logic out_valid, out_stall;
  logic out_status, out_first_found, out_second_found, out_in_vigilance;
  logic [ID_W-1:0] out_added_id, out_first_id, out_second_id;
  logic [DIST_W-1:0] out_first_dist2, out_second_dist2;

  grid_two_nearest_node_store u_dut (.*);

  // Mirror of the store and its registers
  int              org [3];
  int              inv_cell;
  longint unsigned vig_r2 [4];
  int              npos [NODES][3];
  bit [1:0]        nlabel [NODES];
  bit              nvalid [NODES];
  int              ncell [NODES];
  int              nslot [NODES];
  int              ccount [NCELLS];
  int              cmember [NCELLS][SLOTS];
  int              live;

  answer_t pending_q [$];
  int      errors;
  bit      calm;
  int      stuck_cnt;
  int      hold_cnt, hold_ask, hold_done;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------- predictor ----------------
  function automatic longint grid_coord(int p, int o);
    longint prod;
    prod = longint'(p - o) * inv_cell;
    if (prod < 0) return -((-prod) >>> 18);
    return prod >>> 18;
  endfunction

  function automatic bit locate_cell(int p [3], output int cidx);
    longint c [3];
    cidx = 0;
    for (int a = 0; a < 3; a++) begin
      c[a] = grid_coord(p[a], org[a]);
      if (p[a] - org[a] < 0 || c[a] >= GRID) return 1'b0;
    end
    cidx = int'(c[0] + c[1] * GRID + c[2] * GRID * GRID);
    return 1'b1;
  endfunction

  function automatic void unlink_node(int id);
    int cidx, slot, last, mover;
    cidx = ncell[id];
    slot = nslot[id];
    if (ccount[cidx] == 0) return;
    last = ccount[cidx] - 1;
    ccount[cidx] = last;
    if (slot != last) begin
      mover = cmember[cidx][last];
      nslot[mover] = slot;
      cmember[cidx][slot] = mover;
    end
  endfunction

  function automatic void link_node(int id, int cidx);
    ncell[id] = cidx;
    nslot[id] = ccount[cidx];
    cmember[cidx][ccount[cidx]] = id;
    ccount[cidx]++;
  endfunction

  function automatic answer_t apply_request(mode_t m, int p [3], int tgt, bit [1:0] lab);
    answer_t r;
    int cidx, id, lo [3], hi [3];
    longint c;
    longint unsigned dsum;
    r = '{default: 0};
    r.status = 1'b1;
    case (m)
      MODE_ADD: begin
        if (live < NODES && locate_cell(p, cidx) && ccount[cidx] < SLOTS) begin
          id = 0;
          while (id < NODES && nvalid[id]) id++;
          nvalid[id] = 1'b1;
          nlabel[id] = lab;
          npos[id] = p;
          link_node(id, cidx);
          live++;
          r.status = 1'b0;
          r.added_id = id[9:0];
        end
      end
      MODE_MOVE: begin
        if (nvalid[tgt] && locate_cell(p, cidx) &&
            (cidx == ncell[tgt] || ccount[cidx] < SLOTS)) begin
          npos[tgt] = p;
          if (cidx != ncell[tgt]) begin
            unlink_node(tgt);
            link_node(tgt, cidx);
          end
          r.status = 1'b0;
        end
      end
      MODE_DELETE: begin
        if (nvalid[tgt] && live > 2) begin
          unlink_node(tgt);
          nvalid[tgt] = 1'b0;
          live--;
          r.status = 1'b0;
        end
      end
      default: begin
        r.status = 1'b0;
        for (int a = 0; a < 3; a++) begin
          c = grid_coord(p[a], org[a]);
          lo[a] = (c - 1 < 0) ? 0 : int'(c - 1);
          hi[a] = (c + 1 > GRID - 1) ? GRID - 1 : int'(c + 1);
        end
        // Scan the window in x, y, z, slot order; strict less-than keeps earlier ties
        for (int x = lo[0]; x <= hi[0]; x++)
          for (int y = lo[1]; y <= hi[1]; y++)
            for (int z = lo[2]; z <= hi[2]; z++) begin
              cidx = x + y * GRID + z * GRID * GRID;
              for (int s = 0; s < ccount[cidx]; s++) begin
                id = cmember[cidx][s];
                dsum = 0;
                for (int a = 0; a < 3; a++)
                  dsum += longint'(p[a] - npos[id][a]) * longint'(p[a] - npos[id][a]);
                if (!r.f2 || dsum < r.d2) begin
                  if (!r.f1 || dsum < r.d1) begin
                    r.f2 = r.f1; r.id2 = r.id1; r.d2 = r.d1;
                    r.f1 = 1'b1; r.id1 = id[9:0]; r.d1 = dsum[35:0];
                  end else begin
                    r.f2 = 1'b1; r.id2 = id[9:0]; r.d2 = dsum[35:0];
                  end
                end
                if (dsum < vig_r2[nlabel[id]]) r.vig = 1'b1;
              end
            end
      end
    endcase
    return r;
  endfunction

  // ---------------- drivers ----------------
  // Drive one register write; the caller drops the write enable after the last one
  task automatic write_reg(cfg_reg_t idx, longint unsigned val);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val[35:0];
    @(posedge clk);
    case (idx)
      CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z: org[idx] = int'($signed(val[15:0]));
      CFG_INV_CELL: inv_cell = int'(val[15:0]);
      default:      vig_r2[idx - CFG_VIG_L0] = val & VIG_MAX;
    endcase
  endtask

  // Hold the sender until every expected result has arrived
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_grid(int ox, int oy, int oz, int inv, longint unsigned v0,
                          longint unsigned v1, longint unsigned v2, longint unsigned v3);
    wait_drain();
    repeat (8) @(posedge clk);
    write_reg(CFG_ORIGIN_X, ox);
    write_reg(CFG_ORIGIN_Y, oy);
    write_reg(CFG_ORIGIN_Z, oz);
    write_reg(CFG_INV_CELL, inv);
    write_reg(CFG_VIG_L0, v0);
    write_reg(CFG_VIG_L1, v1);
    write_reg(CFG_VIG_L2, v2);
    write_reg(CFG_VIG_L3, v3);
    cfg_wr_en <= 1'b0;
  endtask

  // Offer one request, predict on acceptance, then maybe idle
  task automatic send_request(mode_t m, int px, int py, int pz, int tgt, int lab);
    int p [3];
    in_valid     <= 1'b1;
    in_mode      <= m;
    in_pos_x     <= px[15:0];
    in_pos_y     <= py[15:0];
    in_pos_z     <= pz[15:0];
    in_target_id <= tgt[9:0];
    in_new_label <= lab[1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = '{int'($signed(px[15:0])), int'($signed(py[15:0])), int'($signed(pz[15:0]))};
    pending_q.push_back(apply_request(m, p, tgt & 10'h3FF, lab[1:0]));
    if (!calm && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // Coordinate near the low corner of the grid on one axis, or anywhere at all
  function automatic int pick_coord(int o);
    int span, v;
    if ($urandom_range(99) < 12) return int'($urandom_range(65535)) - 32768;
    span = (inv_cell == 0) ? 8192 : (1 << 18) / inv_cell;
    v = o + int'($urandom_range(0, 4 * span));
    return (v > 32767) ? 32767 : v;
  endfunction

  function automatic int pick_node();
    int id;
    if ($urandom_range(99) < 15 || live == 0) return int'($urandom_range(1023));
    id = int'($urandom_range(1023));
    while (!nvalid[id]) id = (id + 1) % NODES;
    return id;
  endfunction

  task automatic run_random(int n);
    int r;
    mode_t m;
    for (int i = 0; i < n; i++) begin
      r = int'($urandom_range(99));
      m = (r < 35) ? MODE_ADD : (r < 55) ? MODE_MOVE : (r < 70) ? MODE_DELETE : MODE_QUERY;
      send_request(m, pick_coord(org[0]), pick_coord(org[1]), pick_coord(org[2]),
                   pick_node(), int'($urandom_range(3)));
    end
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    set_grid(0, 0, 0, 256, 200000, 0, VIG_MAX, 5000);
    send_request(MODE_QUERY, 0, 0, 0, 0, 0);             // empty store
    send_request(MODE_DELETE, 0, 0, 0, 0, 0);            // absent node
    send_request(MODE_ADD, -1, 0, 0, 0, 0);              // below the origin
    send_request(MODE_ADD, 32767, 0, 0, 0, 0);           // beyond the last cell
    send_request(MODE_ADD, 100, 100, 100, 0, 0);
    send_request(MODE_ADD, 900, 200, 50, 0, 1);
    send_request(MODE_DELETE, 0, 0, 0, 1, 0);            // too few nodes left
    send_request(MODE_ADD, 2048, 0, 0, 0, 2);
    send_request(MODE_ADD, 1500, 1500, 1500, 0, 3);
    send_request(MODE_MOVE, 0, 0, 0, 700, 0);            // absent node
    send_request(MODE_MOVE, -32768, -32768, -32768, 0, 0);
    send_request(MODE_MOVE, 300, 300, 300, 0, 0);        // same cell
    send_request(MODE_MOVE, 5000, 5000, 5000, 1, 0);     // other cell
    send_request(MODE_QUERY, 500, 500, 500, 0, 0);
    send_request(MODE_QUERY, -32768, -32768, -32768, 0, 0); // empty window below
    send_request(MODE_QUERY, 32767, 32767, 32767, 0, 0);    // empty window above
    send_request(MODE_DELETE, 0, 0, 0, 1, 0);
    // Fill the top corner cell, then overflow it
    for (int i = 0; i < SLOTS + 1; i++)
      send_request(MODE_ADD, 16000 + 30 * i, 16000, 16000, 0, i % 4);
    send_request(MODE_MOVE, 16100, 16100, 16100, 0, 0);  // full target cell
    send_request(MODE_QUERY, 16383, 16383, 16383, 0, 0);
  endtask

  task automatic test_default_random();
    run_random(150);
    calm = 1'b1;
    run_random(80);
    calm = 1'b0;
  endtask

  task automatic test_backpressure();
    set_grid(-8192, -4000, 1234, 512, 1 << 22, 1 << 16, 300000, VIG_MAX);
    run_random(60);
    calm = 1'b1;
    hold_ask <= hold_ask + 1;
    run_random(40);
    calm = 1'b0;
    wait_drain();
    run_random(100);
  endtask

  task automatic test_extremes();
    set_grid(-32768, -32768, -32768, 65535, 0, VIG_MAX, 0, VIG_MAX);
    run_random(100);
    set_grid(32767, 32767, 32767, 0, VIG_MAX, 0, VIG_MAX, 1);
    run_random(50);
    set_grid(-32768, 0, 32767, 1, 123456789, 7, 1 << 30, 42);
    run_random(30);
  endtask

  // ---------------- result checker and receiver stall ----------------
  function automatic void compare_field(string nm, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    answer_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        $display("%0t: result with nothing expected", $time);
        errors++;
      end else begin
        e = pending_q.pop_front();
        compare_field("status", e.status, out_status);
        compare_field("added_id", e.added_id, out_added_id);
        compare_field("first_found", e.f1, out_first_found);
        compare_field("first_id", e.id1, out_first_id);
        compare_field("first_dist2", e.d1, out_first_dist2);
        compare_field("second_found", e.f2, out_second_found);
        compare_field("second_id", e.id2, out_second_id);
        compare_field("second_dist2", e.d2, out_second_dist2);
        compare_field("in_vigilance", e.vig, out_in_vigilance);
      end
    end
    out_stall <= rst_n && ((hold_cnt != 0) || (!calm && $urandom_range(99) < 21));
  end

  // Long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_cnt != 0) hold_cnt <= hold_cnt - 1;
    else if (hold_ask != hold_done) begin
      hold_cnt  <= 400;
      hold_done <= hold_ask;
    end
  end

  // Watchdog on cycles with no request or result accepted
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) stuck_cnt <= 0;
    else stuck_cnt <= stuck_cnt + 1;
    if (stuck_cnt >= STUCK_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n        <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_index    <= CFG_ORIGIN_X;
    cfg_wr_data  <= '0;
    in_valid     <= 1'b0;
    in_mode      <= MODE_ADD;
    in_pos_x     <= '0;
    in_pos_y     <= '0;
    in_pos_z     <= '0;
    in_target_id <= '0;
    in_new_label <= '0;
    out_stall    <= 1'b0;
    errors = 0;
    calm = 1'b0;
    hold_cnt = 0;
    hold_ask = 0;
    hold_done = 0;
    stuck_cnt = 0;
    live = 0;
    org = '{0, 0, 0};
    inv_cell = INV_RESET;
    vig_r2 = '{0, 0, 0, 0};
    for (int i = 0; i < NODES; i++) nvalid[i] = 1'b0;
    for (int i = 0; i < NCELLS; i++) ccount[i] = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_default_random();
    test_backpressure();
    test_extremes();

    wait_drain();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
